>>> src/bmm_pkg.sv
// shared constants, codes and request structs for the bracket match marker
package bmm_pkg;

    // string capacity and derived widths
    localparam int MAX_LEN = 512;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // command codes
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // mark codes
    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_OPEN  = 2'd1;
    localparam logic [1:0] MARK_CLOSE = 2'd2;

    // bracket bytes
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // character and mark store access
    typedef struct packed {
        logic             char_we;
        logic [IDX_W-1:0] char_addr;
        logic [7:0]       char_data;
        logic             mark_we;
        logic [IDX_W-1:0] mark_addr;
        logic [1:0]       mark_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_store_req;

    // open position stack access
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             rd_en;
        logic [IDX_W-1:0] raddr;
    } t_stack_req;

endpackage

>>> src/bmm_if.sv
// command and response channel interfaces

// command channel
interface bmm_cmd_if;
    import bmm_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_in;
    logic [8:0] read_index;

    modport source (output valid, output command, output char_in, output read_index,
                    input ready);
    modport sink   (input valid, input command, input char_in, input read_index,
                    output ready);
endinterface

// response channel
interface bmm_rsp_if;
    import bmm_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] mark;
    logic [7:0] char_out;
    logic       in_range;
    logic       overflow;

    modport source (output valid, output mark, output char_out, output in_range,
                    output overflow, input ready);
    modport sink   (input valid, input mark, input char_out, input in_range,
                    input overflow, output ready);
endinterface

>>> src/bracket_match_marker.sv
// top level: command decode, stack pointer, string length and response register
//
//  channel    dir  handshake      payload
//  i_cmd_ch   in   valid/ready    command, char_in, read_index
//  o_rsp_ch   out  valid/ready    mark, char_out, in_range, overflow
//
// start, append of a plain byte or '(' and a full-string append complete in the idle state
// append of ')' with open brackets pending does a stack read, then a mark clear in S_POP
// read does a memory read, then a load of the response register in S_READ
// a read waits in S_READ while the response register holds an untaken result
// reset clears length, stack depth and overflow; the memories need no clearing
module bracket_match_marker
    import bmm_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmm_cmd_if.sink        i_cmd_ch,
    bmm_rsp_if.source      o_rsp_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_depth, n_depth;
    logic             r_ovf, n_ovf;
    logic             r_ok, n_ok;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_mark;
    logic [7:0]       r_out_char;
    logic             r_out_in_range;
    logic             r_out_ovf;

    t_store_req       st_req;
    t_stack_req       sk_req;
    logic [7:0]       rd_char;
    logic [1:0]       rd_mark;
    logic [IDX_W-1:0] top_pos;
    logic             in_acc;
    logic             out_load;
    logic [IDX_W-1:0] pos;
    logic [LEN_W-1:0] depth_dec;
    logic             full;

    bmm_store u_store (
        .i_clk     (i_clk),
        .i_req     (st_req),
        .o_rd_char (rd_char),
        .o_rd_mark (rd_mark)
    );

    bmm_stack u_stack (
        .i_clk    (i_clk),
        .i_req    (sk_req),
        .o_rd_pos (top_pos)
    );

    assign i_cmd_ch.ready = (r_state == S_IDLE);
    assign in_acc         = i_cmd_ch.valid && i_cmd_ch.ready;
    assign pos            = r_len[IDX_W-1:0];
    assign depth_dec      = r_depth - 1'b1;
    assign full           = (r_len == LEN_W'(MAX_LEN));

    // command decode and sequencing
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_depth  = r_depth;
        n_ovf    = r_ovf;
        n_ok     = r_ok;
        st_req   = '0;
        sk_req   = '0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd_ch.command)
                        CMD_START: begin
                            n_len   = '0;
                            n_depth = '0;
                            n_ovf   = 1'b0;
                        end
                        CMD_APPEND: begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                st_req.char_we   = 1'b1;
                                st_req.char_addr = pos;
                                st_req.char_data = i_cmd_ch.char_in;
                                st_req.mark_we   = 1'b1;
                                st_req.mark_addr = pos;
                                st_req.mark_data = MARK_NONE;
                                n_len            = r_len + 1'b1;
                                if (i_cmd_ch.char_in == CH_OPEN) begin
                                    st_req.mark_data = MARK_OPEN;
                                    sk_req.we        = 1'b1;
                                    sk_req.waddr     = r_depth[IDX_W-1:0];
                                    sk_req.wdata     = pos;
                                    n_depth          = r_depth + 1'b1;
                                end else if (i_cmd_ch.char_in == CH_CLOSE) begin
                                    if (r_depth != '0) begin
                                        // pop: fetch the partner position
                                        sk_req.rd_en = 1'b1;
                                        sk_req.raddr = depth_dec[IDX_W-1:0];
                                        n_depth      = depth_dec;
                                        n_state      = S_POP;
                                    end else begin
                                        st_req.mark_data = MARK_CLOSE;
                                    end
                                end
                            end
                        end
                        CMD_READ: begin
                            st_req.rd_en   = 1'b1;
                            st_req.rd_addr = i_cmd_ch.read_index;
                            n_ok           = (LEN_W'(i_cmd_ch.read_index) < r_len);
                            n_state        = S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                // clear the mark of the matched open bracket
                st_req.mark_we   = 1'b1;
                st_req.mark_addr = top_pos;
                st_req.mark_data = MARK_NONE;
                n_state          = S_IDLE;
            end
            S_READ: begin
                if (!r_out_valid || o_rsp_ch.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = out_load || (r_out_valid && !o_rsp_ch.ready);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_depth     <= '0;
            r_ovf       <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_depth     <= n_depth;
            r_ovf       <= n_ovf;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // response payload register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mark     <= r_ok ? rd_mark : MARK_NONE;
            r_out_char     <= r_ok ? rd_char : 8'h00;
            r_out_in_range <= r_ok;
            r_out_ovf      <= r_ovf;
        end
    end

    assign o_rsp_ch.valid    = r_out_valid;
    assign o_rsp_ch.mark     = r_out_mark;
    assign o_rsp_ch.char_out = r_out_char;
    assign o_rsp_ch.in_range = r_out_in_range;
    assign o_rsp_ch.overflow = r_out_ovf;

endmodule

>>> src/bmm_store.sv
// character and mark memories with registered read
module bmm_store
    import bmm_pkg::*;
(
    input  logic       i_clk,
    input  t_store_req i_req,
    output logic [7:0] o_rd_char,
    output logic [1:0] o_rd_mark
);

    logic [7:0] r_char_mem [MAX_LEN];
    logic [1:0] r_mark_mem [MAX_LEN];

    // character memory
    always_ff @(posedge i_clk) begin
        if (i_req.char_we) begin
            r_char_mem[i_req.char_addr] <= i_req.char_data;
        end
        if (i_req.rd_en) begin
            o_rd_char <= r_char_mem[i_req.rd_addr];
        end
    end

    // mark memory
    always_ff @(posedge i_clk) begin
        if (i_req.mark_we) begin
            r_mark_mem[i_req.mark_addr] <= i_req.mark_data;
        end
        if (i_req.rd_en) begin
            o_rd_mark <= r_mark_mem[i_req.rd_addr];
        end
    end

endmodule

>>> src/bmm_stack.sv
// open bracket position stack memory with registered read
module bmm_stack
    import bmm_pkg::*;
(
    input  logic             i_clk,
    input  t_stack_req       i_req,
    output logic [IDX_W-1:0] o_rd_pos
);

    logic [IDX_W-1:0] r_mem [MAX_LEN];

    // push write and top read
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            o_rd_pos <= r_mem[i_req.raddr];
        end
    end

endmodule

>>> src/bmm_checker.sv
// port-level checks for the bracket match marker, bound to the top level
module bmm_checker
    import bmm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_command,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_mark,
    input logic [7:0] i_char_out,
    input logic       i_in_range
);

    logic rd_acc;
    assign rd_acc = i_in_valid && i_in_ready && (i_command == CMD_READ);

    // a response into an empty register rises only after an accepted read transaction
    a_rsp_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(rd_acc, 2))
        else $error("response without a read transaction two cycles before");

    // an accepted read drops command ready while the read is in S_READ
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> !i_in_ready)
        else $error("command accepted while a read is in flight");

    // out of range reads give zero payload
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_in_range) |-> (i_mark == MARK_NONE && i_char_out == 8'h00))
        else $error("out of range response carries data");

    // a stalled response stays valid
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("response dropped while stalled");

endmodule

bind bracket_match_marker bmm_checker u_bmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd_ch.valid),
    .i_in_ready  (i_cmd_ch.ready),
    .i_command   (i_cmd_ch.command),
    .i_out_valid (o_rsp_ch.valid),
    .i_out_ready (o_rsp_ch.ready),
    .i_mark      (o_rsp_ch.mark),
    .i_char_out  (o_rsp_ch.char_out),
    .i_in_range  (o_rsp_ch.in_range)
);
